### rtl/nct_pkg.sv
// nct_pkg: shared types, constants and helpers for the nhit coincidence trigger
// no dependencies

package nct_pkg;

  // channel word and per-tick count widths
  localparam int unsigned LEVELS_W  = 64;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned TICK_W    = 48;

  // popcount split into groups of eight channels
  localparam int unsigned GROUP_N   = 8;
  localparam int unsigned GROUP_W   = LEVELS_W / GROUP_N;
  localparam int unsigned GCNT_W    = 4;

  // configuration register widths and indexes
  localparam int unsigned THR_W     = 7;
  localparam int unsigned BEGIN_W   = 12;
  localparam int unsigned END_W     = 11;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HIT_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_BEGIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_END      = 2'd2;

  // register reset values
  localparam logic [THR_W-1:0]   THR_RESET   = 7'd10;
  localparam logic [BEGIN_W-1:0] BEGIN_RESET = 12'hF9C;
  localparam logic [END_W-1:0]   END_RESET   = 11'd400;

  // gate length as signed, lockout counter as unsigned (at most 4094)
  localparam int unsigned GLEN_W    = 13;
  localparam int unsigned LOCK_W    = 12;

  // upper bound on reported count
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd64;

  // one classified tick, as handed from front to back
  typedef struct packed {
    logic                            rising_any;
    logic [GROUP_N-1:0][GCNT_W-1:0]  part_cnt;
  } tick_entry_t;

  // popcount of one group of eight channels
  function automatic logic [GCNT_W-1:0] popcount8(input logic [GROUP_W-1:0] v);
    logic [GCNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < GROUP_W; i++) begin
      n = n + GCNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

### rtl/nct_front.sv
// nct_front: accepts level words, finds rising edges, forms group counts
// depends on nct_pkg

module nct_front #(
  parameter int unsigned NUM_CHANNELS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [nct_pkg::LEVELS_W-1:0]        in_channel_levels,
  input  logic                                q_full,
  output logic                                q_push,
  output nct_pkg::tick_entry_t                q_wdata
);

  localparam logic [nct_pkg::LEVELS_W-1:0] CHAN_MASK =
    {nct_pkg::LEVELS_W{1'b1}} >> (nct_pkg::LEVELS_W - NUM_CHANNELS);

  logic [nct_pkg::LEVELS_W-1:0] prev_r;
  logic [nct_pkg::LEVELS_W-1:0] prev_nxt;
  logic [nct_pkg::LEVELS_W-1:0] levels;

  // request handshake: take a tick whenever the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // classify: mask unused channels, rising edges, per-group counts
  always_comb begin
    levels               = in_channel_levels & CHAN_MASK;
    q_wdata.rising_any   = |(levels & ~prev_r);
    for (int g = 0; g < nct_pkg::GROUP_N; g++) begin
      q_wdata.part_cnt[g] =
        nct_pkg::popcount8(levels[g*nct_pkg::GROUP_W +: nct_pkg::GROUP_W]);
    end
    prev_nxt = q_push ? levels : prev_r;
  end

  // previous levels follow every accepted tick, lockout or not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

### rtl/nct_queue.sv
// nct_queue: two-entry queue of classified ticks between front and back
// depends on nct_pkg

module nct_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  nct_pkg::tick_entry_t  wdata,
  output logic                  full,
  input  logic                  pop,
  output logic                  rvalid,
  output nct_pkg::tick_entry_t  rdata
);

  nct_pkg::tick_entry_t mem_r [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;

  assign full   = (cnt_r == 2'd2);
  assign rvalid = (cnt_r != 2'd0);
  assign rdata  = mem_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### rtl/nct_back.sv
// nct_back: sums group counts, applies threshold and lockout, stamps ticks
// depends on nct_pkg

module nct_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  nct_pkg::tick_entry_t            q_rdata,
  output logic                            q_pop,
  input  logic [nct_pkg::THR_W-1:0]       hit_threshold,
  input  logic [nct_pkg::BEGIN_W-1:0]     gate_begin_offset,
  input  logic [nct_pkg::END_W-1:0]       gate_end_offset,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_trigger_fired,
  output logic [nct_pkg::COUNT_W-1:0]     out_active_count,
  output logic [nct_pkg::TICK_W-1:0]      out_trigger_tick
);

  logic                          ovalid_r, ovalid_nxt;
  logic                          fired_r;
  logic [nct_pkg::COUNT_W-1:0]   count_r;
  logic [nct_pkg::TICK_W-1:0]    ttick_r;
  logic [nct_pkg::TICK_W-1:0]    tick_r, tick_nxt;
  logic [nct_pkg::LOCK_W-1:0]    lock_r, lock_nxt;

  logic [nct_pkg::COUNT_W-1:0]   count;
  logic signed [nct_pkg::GLEN_W-1:0] glen;
  logic                          locked;
  logic                          fire;

  // take the next tick when the output register is free or being emptied
  assign q_pop = q_valid && (!ovalid_r || !out_stall);

  // active count, gate length, fire decision and lockout
  always_comb begin
    count = '0;
    for (int g = 0; g < nct_pkg::GROUP_N; g++) begin
      count = count + nct_pkg::COUNT_W'(q_rdata.part_cnt[g]);
    end
    glen   = $signed({2'b00, gate_end_offset})
           - $signed({gate_begin_offset[nct_pkg::BEGIN_W-1], gate_begin_offset});
    locked = (lock_r != '0);
    fire   = !locked && q_rdata.rising_any && (count >= hit_threshold);

    lock_nxt = lock_r;
    tick_nxt = tick_r;
    if (q_pop) begin
      tick_nxt = tick_r + 1'b1;
      if (fire) begin
        lock_nxt = (glen > 0) ? nct_pkg::LOCK_W'(glen - 1) : '0;
      end else if (locked) begin
        lock_nxt = lock_r - 1'b1;
      end
    end
    ovalid_nxt = q_pop || (ovalid_r && out_stall);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      tick_r   <= '0;
      lock_r   <= '0;
    end else begin
      ovalid_r <= ovalid_nxt;
      tick_r   <= tick_nxt;
      lock_r   <= lock_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      fired_r <= fire;
      count_r <= count;
      ttick_r <= fire ? tick_r : '0;
    end
  end

  assign out_valid         = ovalid_r;
  assign out_trigger_fired = fired_r;
  assign out_active_count  = count_r;
  assign out_trigger_tick  = ttick_r;

endmodule

### rtl/nhit_coincidence_trigger.sv
// nhit_coincidence_trigger: top level of the multiplicity trigger with lockout
// depends on nct_pkg, nct_front, nct_queue, nct_back
//
//   channel  direction  handshake           payload
//   in_      request    in_valid/in_stall   in_channel_levels[63:0]
//   out_     result     out_valid/out_stall fired, active_count[6:0], trigger_tick[47:0]
//   cfg_     write      cfg_we              cfg_index[1:0], cfg_data[11:0]
//
// one tick per cycle sustained while out_stall is low; a taken request is written
// into the queue, then popped into the output register, where out_valid rises
// the front classifies into a two-entry queue, the back fills one output register
// in_stall rises only when the queue is full, i.e. after out_stall backs it up
// synchronous active-low reset clears history, lockout, tick count, queue, out_valid

module nhit_coincidence_trigger #(
  parameter int unsigned NUM_CHANNELS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [nct_pkg::LEVELS_W-1:0]      in_channel_levels,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_trigger_fired,
  output logic [nct_pkg::COUNT_W-1:0]       out_active_count,
  output logic [nct_pkg::TICK_W-1:0]        out_trigger_tick,
  input  logic                              cfg_we,
  input  logic [nct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nct_pkg::CFG_W-1:0]         cfg_data
);

  logic [nct_pkg::THR_W-1:0]   thr_r;
  logic [nct_pkg::BEGIN_W-1:0] begin_r;
  logic [nct_pkg::END_W-1:0]   end_r;

  logic                  q_push, q_full, q_pop, q_valid;
  nct_pkg::tick_entry_t  q_wdata, q_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= nct_pkg::THR_RESET;
      begin_r <= nct_pkg::BEGIN_RESET;
      end_r   <= nct_pkg::END_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nct_pkg::REG_HIT_THRESHOLD: thr_r   <= cfg_data[nct_pkg::THR_W-1:0];
        nct_pkg::REG_GATE_BEGIN:    begin_r <= cfg_data[nct_pkg::BEGIN_W-1:0];
        nct_pkg::REG_GATE_END:      end_r   <= cfg_data[nct_pkg::END_W-1:0];
        default: ;
      endcase
    end
  end

  // front: accept and classify
  nct_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_channel_levels (in_channel_levels),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_wdata           (q_wdata)
  );

  // queue between the halves
  nct_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  // back: decide and report
  nct_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .hit_threshold     (thr_r),
    .gate_begin_offset (begin_r),
    .gate_end_offset   (end_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_trigger_fired (out_trigger_fired),
    .out_active_count  (out_active_count),
    .out_trigger_tick  (out_trigger_tick)
  );

endmodule

### rtl/nct_checker.sv
// nct_checker: port-level checks on the trigger's result channel, with bind
// depends on nct_pkg and nhit_coincidence_trigger

module nct_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_trigger_fired,
  input  logic [nct_pkg::COUNT_W-1:0]   out_active_count,
  input  logic [nct_pkg::TICK_W-1:0]    out_trigger_tick
);

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a result with no trigger carries a zero stamp
  a_no_fire_zero_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_trigger_fired) |-> (out_trigger_tick == '0))
    else $error("trigger tick set without a trigger");

  // count never exceeds COUNT_MAX, the full 64-channel word
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_active_count <= nct_pkg::COUNT_MAX))
    else $error("active count out of range");

  // a stalled result stays put
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_trigger_fired)
      && $stable(out_active_count) && $stable(out_trigger_tick)))
    else $error("stalled result changed");

endmodule

bind nhit_coincidence_trigger nct_checker u_nct_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_trigger_fired (out_trigger_fired),
  .out_active_count  (out_active_count),
  .out_trigger_tick  (out_trigger_tick)
);
